FILE: design/tlsmfl_pkg.sv
// Shared types and constants for the TLS hello max_fragment_length rewriter.
package tlsmfl_pkg;

	localparam int LengthBitsDefault = 16;
	localparam int FifoDepthDefault = 4;
	localparam int SumBits = 18;

	localparam logic [7:0] REC_HANDSHAKE = 8'd22;
	localparam logic [7:0] HELLO_CLIENT = 8'h01;
	localparam logic [7:0] HELLO_SERVER = 8'h02;
	localparam logic [SumBits-1:0] SID_OFFSET = SumBits'(38);
	localparam logic [15:0] EXT_MAX_FRAG = 16'h0001;

	localparam logic CFG_MATCH_VALUE = 1'b0;
	localparam logic CFG_NEW_VALUE = 1'b1;

	typedef enum logic [2:0] {
		ST_ALTERED = 3'd0,
		ST_NO_HANDSHAKE = 3'd1,
		ST_NO_HELLO = 3'd2,
		ST_NO_EXTENSION = 3'd3,
		ST_DIR_MISMATCH = 3'd4,
		ST_VALUE_MISMATCH = 3'd5
	} status_t;

	typedef enum logic [11:0] {
		PH_RTYPE = 12'b0000_0000_0001,
		PH_SKIPLEN = 12'b0000_0000_0010,
		PH_HSLEN = 12'b0000_0000_0100,
		PH_HELLO = 12'b0000_0000_1000,
		PH_SID = 12'b0000_0001_0000,
		PH_CSLEN = 12'b0000_0010_0000,
		PH_COMP = 12'b0000_0100_0000,
		PH_EXTLEN = 12'b0000_1000_0000,
		PH_ETYPE = 12'b0001_0000_0000,
		PH_ELEN = 12'b0010_0000_0000,
		PH_VAL = 12'b0100_0000_0000,
		PH_DONE = 12'b1000_0000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic last;
		status_t status;
	} result_t;

endpackage

FILE: design/tlsmfl_front.sv
// Front end: configuration registers and per-byte hello parser.
module tlsmfl_front #(
	parameter int LengthBits = tlsmfl_pkg::LengthBitsDefault
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [7:0] cfg_index,
	input logic [7:0] cfg_data,
	input logic take,
	input logic [7:0] data_byte,
	input logic [15:0] packet_length,
	input logic dir_srv,
	output tlsmfl_pkg::result_t result
);
	import tlsmfl_pkg::*;

	localparam int W = SumBits;

	logic [7:0] match_q, newval_q;
	logic [LengthBits-1:0] pos_q, pos_d;
	phase_t ph_q, ph_d;
	logic [W-1:0] nb_q, nb_d, re_q, re_d, ee_q, ee_d;
	logic [7:0] acc_q, acc_d;
	logic server_q, server_d;
	logic tgt_q, tgt_d;
	status_t rc_q, rc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 8'd0;
			newval_q <= 8'd1;
		end else if (cfg_we && cfg_index[7:1] == 7'd0) begin
			if (cfg_index[0] == CFG_MATCH_VALUE) match_q <= cfg_data;
			else newval_q <= cfg_data;
		end
	end

	always_comb begin
		logic [W-1:0] posw, pos1, plenw, bw, vw, n;
		logic hi, lo, last;
		logic [15:0] v;
		posw = W'(pos_q);
		pos1 = posw + W'(1);
		plenw = W'(packet_length[LengthBits-1:0]);
		bw = W'(data_byte);
		v = {acc_q, data_byte};
		vw = W'(v);
		hi = (posw == nb_q);
		lo = (posw == nb_q + W'(1));
		n = '0;
		ph_d = ph_q; nb_d = nb_q; re_d = re_q; ee_d = ee_q; acc_d = acc_q;
		server_d = server_q; tgt_d = tgt_q; rc_d = rc_q;
		result.out_byte = data_byte;
		case (ph_q)
			PH_RTYPE: if (hi) begin
				ph_d = (data_byte == REC_HANDSHAKE) ? PH_HSLEN : PH_SKIPLEN;
				nb_d = posw + W'(3);
			end
			PH_SKIPLEN: if (hi) acc_d = data_byte;
			else if (lo) begin
				n = pos1 + vw;
				if (n >= plenw) begin ph_d = PH_DONE; rc_d = ST_NO_HANDSHAKE; end
				else begin nb_d = n; ph_d = PH_RTYPE; end
			end
			PH_HSLEN: if (hi) acc_d = data_byte;
			else if (lo) begin
				n = pos1 + vw;
				if (n > plenw || v == 16'd0) begin ph_d = PH_DONE; rc_d = ST_NO_HELLO; end
				else begin re_d = n; nb_d = pos1; ph_d = PH_HELLO; end
			end
			PH_HELLO: if (hi) begin
				if (data_byte != HELLO_CLIENT && data_byte != HELLO_SERVER) begin
					ph_d = PH_DONE; rc_d = ST_NO_HELLO;
				end else begin
					server_d = (data_byte == HELLO_SERVER);
					n = posw + SID_OFFSET;
					if (n + W'(1) > re_q) begin ph_d = PH_DONE; rc_d = ST_NO_EXTENSION; end
					else begin nb_d = n; ph_d = PH_SID; end
				end
			end
			PH_SID: if (hi) begin
				n = pos1 + bw;
				if (!server_q) begin
					if (n + W'(2) > re_q) begin ph_d = PH_DONE; rc_d = ST_NO_EXTENSION; end
					else begin nb_d = n; ph_d = PH_CSLEN; end
				end else begin
					n = n + W'(2);
					if (n + W'(1) > re_q) begin ph_d = PH_DONE; rc_d = ST_NO_EXTENSION; end
					else begin nb_d = n; ph_d = PH_COMP; end
				end
			end
			PH_CSLEN: if (hi) acc_d = data_byte;
			else if (lo) begin
				n = pos1 + vw;
				if (n + W'(1) > re_q) begin ph_d = PH_DONE; rc_d = ST_NO_EXTENSION; end
				else begin nb_d = n; ph_d = PH_COMP; end
			end
			PH_COMP: if (hi) begin
				n = pos1 + bw;
				if (n + W'(2) > re_q) begin ph_d = PH_DONE; rc_d = ST_NO_EXTENSION; end
				else begin nb_d = n; ph_d = PH_EXTLEN; end
			end
			PH_EXTLEN: if (hi) acc_d = data_byte;
			else if (lo) begin
				n = pos1 + vw;
				if (n > re_q || v < 16'd4) begin ph_d = PH_DONE; rc_d = ST_NO_EXTENSION; end
				else begin ee_d = n; nb_d = pos1; ph_d = PH_ETYPE; end
			end
			PH_ETYPE: if (hi) acc_d = data_byte;
			else if (lo) begin
				tgt_d = (v == EXT_MAX_FRAG);
				nb_d = pos1;
				ph_d = PH_ELEN;
			end
			PH_ELEN: if (hi) acc_d = data_byte;
			else if (lo) begin
				n = pos1 + vw;
				if (tgt_q) begin
					if (v == 16'd0 || n > ee_q) begin ph_d = PH_DONE; rc_d = ST_NO_EXTENSION; end
					else begin nb_d = pos1; ph_d = PH_VAL; end
				end else begin
					if (n + W'(4) > ee_q) begin ph_d = PH_DONE; rc_d = ST_NO_EXTENSION; end
					else begin nb_d = n; ph_d = PH_ETYPE; end
				end
			end
			PH_VAL: if (hi) begin
				ph_d = PH_DONE;
				if (dir_srv == server_q) begin
					if (data_byte == match_q) begin
						result.out_byte = newval_q;
						rc_d = ST_ALTERED;
					end else rc_d = ST_VALUE_MISMATCH;
				end else rc_d = ST_DIR_MISMATCH;
			end
			default: ;
		endcase
		last = (pos1 >= plenw);
		result.last = last;
		result.status = ST_ALTERED;
		pos_d = pos_q + LengthBits'(1);
		if (last) begin
			case (ph_d)
				PH_DONE: result.status = rc_d;
				PH_RTYPE, PH_SKIPLEN: result.status = ST_NO_HANDSHAKE;
				PH_HSLEN, PH_HELLO: result.status = ST_NO_HELLO;
				default: result.status = ST_NO_EXTENSION;
			endcase
			pos_d = '0; ph_d = PH_RTYPE; nb_d = '0; re_d = '0; ee_d = '0; acc_d = '0;
			server_d = 1'b0; tgt_d = 1'b0; rc_d = ST_ALTERED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; ph_q <= PH_RTYPE; nb_q <= '0; re_q <= '0; ee_q <= '0;
			acc_q <= '0; server_q <= 1'b0; tgt_q <= 1'b0; rc_q <= ST_ALTERED;
		end else if (take) begin
			pos_q <= pos_d; ph_q <= ph_d; nb_q <= nb_d; re_q <= re_d; ee_q <= ee_d;
			acc_q <= acc_d; server_q <= server_d; tgt_q <= tgt_d; rc_q <= rc_d;
		end
	end

endmodule

FILE: design/tlsmfl_fifo.sv
// Back end: result queue that drives the output stream.
module tlsmfl_fifo #(
	parameter int Depth = tlsmfl_pkg::FifoDepthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input tlsmfl_pkg::result_t push_data,
	input logic pop,
	output tlsmfl_pkg::result_t head,
	output logic not_empty,
	output logic not_full,
	output logic [$clog2(Depth+1)-1:0] level
);
	import tlsmfl_pkg::*;

	localparam int PB = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CB = $clog2(Depth+1);

	result_t mem [Depth];
	logic [PB-1:0] wr_q, rd_q;
	logic [CB-1:0] cnt_q;

	function automatic logic [PB-1:0] bump(input logic [PB-1:0] p);
		return (p == PB'(Depth - 1)) ? '0 : p + PB'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= bump(wr_q);
			if (pop) rd_q <= bump(rd_q);
			if (push && !pop) cnt_q <= cnt_q + CB'(1);
			else if (pop && !push) cnt_q <= cnt_q - CB'(1);
		end
	end

	assign head = mem[rd_q];
	assign not_empty = (cnt_q != '0);
	assign not_full = (cnt_q != CB'(Depth));
	assign level = cnt_q;

endmodule

FILE: design/tls_hello_max_frag_len_rewriter_core.sv
// Top level of the TLS hello max_fragment_length rewriter.
//  channel   dir  handshake              payload
//  s_axis    in   s_axis_tvalid/tready   tdata: data_byte, packet_length, dir_srv
//  m_axis    out  m_axis_tvalid/tready   tdata: out_byte; tlast: last; tuser: status
//  cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
// One byte per cycle while the queue has room; the parser decides each byte in the cycle it is taken.
// Each result is registered into a FifoDepth-entry queue (four by default) that drives m_axis.
// The input stalls only while that queue is full; cfg is always ready.
// Reset returns the parser to the record header phase and empties the queue.
module tls_hello_max_frag_len_rewriter_core #(
	parameter int LengthBits = tlsmfl_pkg::LengthBitsDefault,
	parameter int FifoDepth = tlsmfl_pkg::FifoDepthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [31:0] s_axis_tdata, // data_byte[7:0], packet_length[23:8], dir_srv[24]
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [7:0] m_axis_tdata, // out_byte[7:0]
	output logic m_axis_tlast,
	output logic [2:0] m_axis_tuser, // status[2:0]
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_index,
	input logic [7:0] cfg_data
);
	import tlsmfl_pkg::*;

	logic take, pop, not_full;
	result_t res, head;
	logic [$clog2(FifoDepth+1)-1:0] level;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = not_full;
	assign take = s_axis_tvalid && not_full;
	assign pop = m_axis_tvalid && m_axis_tready;

	tlsmfl_front #(.LengthBits(LengthBits)) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.take(take),
		.data_byte(s_axis_tdata[7:0]),
		.packet_length(s_axis_tdata[23:8]),
		.dir_srv(s_axis_tdata[24]),
		.result(res)
	);

	tlsmfl_fifo #(.Depth(FifoDepth)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(take), .push_data(res), .pop(pop),
		.head(head), .not_empty(m_axis_tvalid), .not_full(not_full), .level(level)
	);

	assign m_axis_tdata = head.out_byte;
	assign m_axis_tlast = head.last;
	assign m_axis_tuser = head.status;

`ifndef SYNTHESIS
	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_ALTERED |-> m_axis_tlast)
		else $error("status without last");
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= ($clog2(FifoDepth+1))'(FifoDepth))
		else $error("queue overflow");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		take && !pop |=> m_axis_tvalid)
		else $error("pushed word lost");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the TLS hello max_fragment_length rewriter core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tlsmfl_pkg::*;

	typedef struct {
		logic [7:0] data_byte;
		logic [15:0] pkt_len;
		bit from_srv;
		bit typed;
		result_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic m_axis_tlast;
	logic [2:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	tls_hello_max_frag_len_rewriter_core uut (.*);

	always #5 clk = ~clk;

	// rewriter shadow state
	logic [7:0] match_code = 8'd0, repl_code = 8'd1;
	logic [31:0] byte_pos, next_pos, hi_byte, hello_pos, rec_end, ext_end;
	phase_t parse_ph;
	logic [7:0] hs_kind;
	bit ext_hit;
	status_t verdict;

	result_t pending_words[$];
	logic [7:0] pkt[$];
	dir_row_t dir_rows[$];
	int mismatches = 0, words_in = 0, words_out = 0, packets = 0;
	int status_seen[6];
	int burst_left = 0, hold_cnt = 0, stall_pct = 0, stall_age = 0, idle_cycles = 0;
	bit hold_req = 0;

	task automatic reset_parse();
		byte_pos = 0; next_pos = 0; hi_byte = 0; hello_pos = 0; rec_end = 0; ext_end = 0;
		parse_ph = PH_RTYPE; hs_kind = 0; ext_hit = 0; verdict = ST_ALTERED;
	endtask

	task automatic conclude(input status_t s);
		parse_ph = PH_DONE;
		verdict = s;
	endtask

	function automatic bit grab16(input logic [31:0] pos, input logic [7:0] b,
			output logic [31:0] val);
		val = 0;
		if (pos == next_pos) begin
			hi_byte = {24'd0, b};
			return 0;
		end
		if (pos == next_pos + 1) begin
			val = {16'd0, hi_byte[7:0], b};
			return 1;
		end
		return 0;
	endfunction

	task automatic predict_rewrite(input logic [7:0] b, input logic [15:0] len_in, input bit fs,
			output result_t r);
		logic [31:0] pos, plen, v, n;
		logic [7:0] ob;
		pos = {16'd0, byte_pos[15:0]};
		plen = {16'd0, len_in};
		ob = b;
		v = 0;
		case (parse_ph)
			PH_RTYPE: if (pos == next_pos) begin
				parse_ph = (b == REC_HANDSHAKE) ? PH_HSLEN : PH_SKIPLEN;
				next_pos = pos + 3;
			end
			PH_SKIPLEN: if (grab16(pos, b, v)) begin
				n = pos + 1 + v;
				if (n >= plen) conclude(ST_NO_HANDSHAKE);
				else begin
					next_pos = n; parse_ph = PH_RTYPE;
				end
			end
			PH_HSLEN: if (grab16(pos, b, v)) begin
				n = pos + 1 + v;
				if (n > plen || v == 0) conclude(ST_NO_HELLO);
				else begin
					rec_end = n; next_pos = pos + 1; parse_ph = PH_HELLO;
				end
			end
			PH_HELLO: if (pos == next_pos) begin
				if (b != HELLO_CLIENT && b != HELLO_SERVER) conclude(ST_NO_HELLO);
				else begin
					hs_kind = b; hello_pos = pos;
					n = pos + 38;
					if (n + 1 > rec_end) conclude(ST_NO_EXTENSION);
					else begin
						next_pos = n; parse_ph = PH_SID;
					end
				end
			end
			PH_SID: if (pos == next_pos) begin
				n = pos + 1 + b;
				if (hs_kind == HELLO_CLIENT) begin
					if (n + 2 > rec_end) conclude(ST_NO_EXTENSION);
					else begin
						next_pos = n; parse_ph = PH_CSLEN;
					end
				end else begin
					n = n + 2;
					if (n + 1 > rec_end) conclude(ST_NO_EXTENSION);
					else begin
						next_pos = n; parse_ph = PH_COMP;
					end
				end
			end
			PH_CSLEN: if (grab16(pos, b, v)) begin
				n = pos + 1 + v;
				if (n + 1 > rec_end) conclude(ST_NO_EXTENSION);
				else begin
					next_pos = n; parse_ph = PH_COMP;
				end
			end
			PH_COMP: if (pos == next_pos) begin
				n = pos + 1 + b;
				if (n + 2 > rec_end) conclude(ST_NO_EXTENSION);
				else begin
					next_pos = n; parse_ph = PH_EXTLEN;
				end
			end
			PH_EXTLEN: if (grab16(pos, b, v)) begin
				n = pos + 1;
				if (n + v > rec_end || v < 4) conclude(ST_NO_EXTENSION);
				else begin
					ext_end = n + v; next_pos = n; parse_ph = PH_ETYPE;
				end
			end
			PH_ETYPE: if (grab16(pos, b, v)) begin
				ext_hit = (v[15:0] == EXT_MAX_FRAG);
				next_pos = pos + 1; parse_ph = PH_ELEN;
			end
			PH_ELEN: if (grab16(pos, b, v)) begin
				n = pos + 1;
				if (ext_hit) begin
					if (v == 0 || n + v > ext_end) conclude(ST_NO_EXTENSION);
					else begin
						next_pos = n; parse_ph = PH_VAL;
					end
				end else begin
					n = n + v;
					if (n + 4 > ext_end) conclude(ST_NO_EXTENSION);
					else begin
						next_pos = n; parse_ph = PH_ETYPE;
					end
				end
			end
			PH_VAL: if (pos == next_pos) begin
				if ((!fs && hs_kind == HELLO_CLIENT) || (fs && hs_kind == HELLO_SERVER)) begin
					if (b == match_code) begin
						ob = repl_code;
						conclude(ST_ALTERED);
					end else conclude(ST_VALUE_MISMATCH);
				end else conclude(ST_DIR_MISMATCH);
			end
			default: ;
		endcase
		r.out_byte = ob;
		r.last = (pos + 1 >= plen);
		r.status = ST_ALTERED;
		if (r.last) begin
			if (parse_ph == PH_DONE) r.status = verdict;
			else if (parse_ph == PH_RTYPE || parse_ph == PH_SKIPLEN) r.status = ST_NO_HANDSHAKE;
			else if (parse_ph == PH_HSLEN || parse_ph == PH_HELLO) r.status = ST_NO_HELLO;
			else r.status = ST_NO_EXTENSION;
			reset_parse();
		end else byte_pos = pos + 1;
	endtask

	task automatic send_word(input logic [7:0] b, input logic [15:0] plen, input bit fs,
			input bit typed, input result_t want);
		result_t r;
		s_axis_tdata <= {7'd0, fs, plen, b};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		words_in++;
		predict_rewrite(b, plen, fs, r);
		pending_words.push_back(typed ? want : r);
		if (burst_left > 0) burst_left--;
		else begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 25);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		wait (pending_words.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == 8'(CFG_MATCH_VALUE)) match_code = val;
		else repl_code = val;
		@(posedge clk);
	endtask

	task automatic build_hello(input bit fs);
		int hs, es, cnt, tgt, ln;
		logic [7:0] kind;
		logic [15:0] etype;
		pkt.delete();
		repeat ($urandom_range(0, 1)) begin
			kind = 8'($urandom_range(0, 255));
			if (kind == REC_HANDSHAKE) kind = 8'd23;
			ln = $urandom_range(0, 6);
			pkt.push_back(kind); pkt.push_back(3); pkt.push_back(3);
			pkt.push_back(0); pkt.push_back(8'(ln));
			repeat (ln) pkt.push_back(8'($urandom_range(0, 255)));
		end
		pkt.push_back(REC_HANDSHAKE); pkt.push_back(3); pkt.push_back(3);
		pkt.push_back(0); pkt.push_back(0);
		hs = pkt.size();
		kind = fs ? HELLO_SERVER : HELLO_CLIENT;
		if ($urandom_range(0, 5) == 0) kind = fs ? HELLO_CLIENT : HELLO_SERVER;
		if ($urandom_range(0, 11) == 0) kind = 8'($urandom_range(0, 255));
		pkt.push_back(kind);
		repeat (3) pkt.push_back(0);
		pkt.push_back(3); pkt.push_back(3);
		repeat (32) pkt.push_back(8'($urandom_range(0, 255)));
		ln = $urandom_range(0, 8);
		pkt.push_back(8'(ln));
		repeat (ln) pkt.push_back(8'($urandom_range(0, 255)));
		if (kind == HELLO_SERVER) repeat (2) pkt.push_back(8'($urandom_range(0, 255)));
		else begin
			ln = 2 * $urandom_range(1, 3);
			pkt.push_back(0); pkt.push_back(8'(ln));
			repeat (ln) pkt.push_back(8'($urandom_range(0, 255)));
		end
		pkt.push_back(1); pkt.push_back(0);
		es = pkt.size();
		pkt.push_back(0); pkt.push_back(0);
		cnt = $urandom_range(0, 3);
		tgt = ($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, cnt);
		for (int i = 0; i <= cnt; i++) begin
			if (i == tgt) begin
				ln = ($urandom_range(0, 11) == 0) ? 0 : 1;
				pkt.push_back(0); pkt.push_back(1); pkt.push_back(0); pkt.push_back(8'(ln));
				if (ln != 0)
					pkt.push_back(($urandom_range(0, 3) != 0) ? match_code :
						8'($urandom_range(0, 255)));
			end else begin
				etype = 16'($urandom_range(0, 65535));
				if (etype == EXT_MAX_FRAG) etype = 16'h0010;
				ln = $urandom_range(0, 4);
				pkt.push_back(etype[15:8]); pkt.push_back(etype[7:0]);
				pkt.push_back(0); pkt.push_back(8'(ln));
				repeat (ln) pkt.push_back(8'($urandom_range(0, 255)));
			end
		end
		ln = pkt.size() - es - 2;
		pkt[es] = ln[15:8]; pkt[es + 1] = ln[7:0];
		ln = pkt.size() - hs;
		pkt[hs - 2] = ln[15:8]; pkt[hs - 1] = ln[7:0];
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 7) == 0)
			pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom_range(0, 255));
	endtask

	task automatic send_packet(input int phase_no);
		bit fs;
		int plen;
		result_t none;
		none = '0;
		fs = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 5) == 0) begin
			pkt.delete();
			repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom_range(0, 255)));
		end else build_hello(fs);
		plen = pkt.size();
		if ($urandom_range(0, 9) == 0) plen = $urandom_range(1, pkt.size());
		if ($urandom_range(0, 29) == 0) plen = plen | 16'h8000;
		packets++;
		foreach (pkt[i]) send_word(pkt[i], plen[15:0], fs, 0, none);
	endtask

	function automatic dir_row_t mk(input logic [7:0] b, input logic [15:0] plen, input bit fs,
			input bit typed = 0, input bit lst = 0, input status_t st = ST_ALTERED);
		dir_row_t d;
		d.data_byte = b; d.pkt_len = plen; d.from_srv = fs; d.typed = typed;
		d.want.out_byte = b; d.want.last = lst; d.want.status = st;
		return d;
	endfunction

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			words_out++;
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word: %h last %b status %0d",
					m_axis_tdata, m_axis_tlast, m_axis_tuser);
			end else begin
				result_t e;
				e = pending_words.pop_front();
				if (m_axis_tdata !== e.out_byte || m_axis_tlast !== e.last ||
						m_axis_tuser !== e.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h/%b/%0d, got %h/%b/%0d", e.out_byte,
							e.last, e.status, m_axis_tdata, m_axis_tlast, m_axis_tuser);
				end else if (e.last) status_seen[e.status]++;
			end
		end
		if (stall_age == 0) begin
			stall_age = 150;
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 10;
				2: stall_pct = 50;
				default: stall_pct = 80;
			endcase
		end else stall_age--;
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 0;
			hold_cnt = 80;
			m_axis_tready <= 1'b0;
		end else m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			idle_cycles = 0;
		else if (++idle_cycles >= 5000) begin
			$display("tls_hello_max_frag_len_rewriter_core regression: fail");
			$finish;
		end
	end

	initial begin
		logic [7:0] mv[5], nv[5];
		int target;
		bit hold_done, pause_done;
		hold_done = 0;
		pause_done = 0;
		mv = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd0};
		nv = '{8'd1, 8'd0, 8'd255, 8'd0, 8'd0};
		mv[3] = 8'($urandom_range(0, 255)); nv[3] = 8'($urandom_range(0, 255));
		mv[4] = 8'($urandom_range(0, 255)); nv[4] = 8'($urandom_range(0, 255));
		reset_parse();
		dir_rows = '{
			mk(8'h00, 16'd1, 0, 1, 1, ST_NO_HANDSHAKE),
			mk(8'hFF, 16'd0, 1, 1, 1, ST_NO_HANDSHAKE),
			mk(8'd23, 16'd5, 0), mk(8'd3, 16'd5, 0), mk(8'd3, 16'd5, 0), mk(8'd0, 16'd5, 0),
			mk(8'd0, 16'd5, 0, 1, 1, ST_NO_HANDSHAKE),
			mk(8'd22, 16'd5, 1), mk(8'd3, 16'd5, 1), mk(8'd3, 16'd5, 1), mk(8'd0, 16'd5, 1),
			mk(8'd0, 16'd5, 1, 1, 1, ST_NO_HELLO),
			mk(8'd22, 16'd6, 0), mk(8'd3, 16'd6, 0), mk(8'd3, 16'd6, 0), mk(8'd0, 16'd6, 0),
			mk(8'd1, 16'd6, 0), mk(8'd3, 16'd6, 0, 1, 1, ST_NO_HELLO),
			mk(8'd22, 16'd6, 0), mk(8'd3, 16'd6, 0), mk(8'd3, 16'd6, 0), mk(8'd0, 16'd6, 0),
			mk(8'd1, 16'd6, 0), mk(8'd1, 16'd6, 0, 1, 1, ST_NO_EXTENSION),
			mk(8'd22, 16'hFFFF, 1), mk(8'h80, 16'd2, 1, 1, 1, ST_NO_HELLO)
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < 5; p++) begin
			if (p > 0) drain();
			write_reg(8'(CFG_MATCH_VALUE), mv[p]);
			write_reg(8'(CFG_NEW_VALUE), nv[p]);
			if (p == 0) foreach (dir_rows[i])
				send_word(dir_rows[i].data_byte, dir_rows[i].pkt_len, dir_rows[i].from_srv,
					dir_rows[i].typed, dir_rows[i].want);
			target = words_in + 290;
			while (words_in < target) begin
				if (p == 2 && !hold_done && words_in + 150 >= target) begin
					hold_req = 1;
					burst_left = 60;
					hold_done = 1;
				end
				if (p == 3 && !pause_done && words_in + 145 >= target) begin
					drain();
					pause_done = 1;
				end
				send_packet(p);
			end
		end
		drain();
		$display("%0d packets, %0d words in, %0d words out over five register settings",
			packets, words_in, words_out);
		$display("verdicts: altered %0d, no handshake %0d, no hello %0d, no ext %0d, dir %0d, value %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
			status_seen[5]);
		if (mismatches == 0 && pending_words.size() == 0)
			$display("tls_hello_max_frag_len_rewriter_core regression: pass");
		else
			$display("tls_hello_max_frag_len_rewriter_core regression: fail");
		$finish;
	end
endmodule
